// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle check: whenever the antecedent holds, the consequent holds too.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle check: the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/wgm_pkg.sv =====
`timescale 1ns / 1ps

package wgm_pkg;

    // Pattern size and derived widths
    localparam int PATTERN_MAX    = 32;
    localparam int POS_W          = PATTERN_MAX + 1;
    localparam int LEN_W          = $clog2(PATTERN_MAX + 1);
    localparam int CLOSE_LEVELS   = $clog2(PATTERN_MAX + 1);
    localparam int CHAR_W         = 8;
    localparam int PLEN_W         = 6;
    localparam int NUM_WORDS      = 4;
    localparam int CHARS_PER_WORD = 8;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHARS_A        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHARS_B        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CHARS_C        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CHARS_D        = 3'd4;

    // Wildcard bytes
    localparam logic [CHAR_W-1:0] CH_ANY_ONE = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_ANY_RUN = 8'h2A;

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [LEN_W-1:0] len_t;
    typedef logic [PATTERN_MAX-1:0][CHAR_W-1:0] pattern_t;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              first_of_string;
        logic              last_of_string;
    } item_t;

endpackage

// ===== design/wgm_close.sv =====
`timescale 1ns / 1ps

// Close a position set over '*': a reachable '*' at i also makes i+1
// reachable. Built as a log-depth prefix network (generate/propagate).
module wgm_close (
    input  wgm_pkg::pos_t                       set_in,
    input  logic [wgm_pkg::PATTERN_MAX-1:0]     run_mask,
    input  wgm_pkg::pos_t                       keep_mask,
    output wgm_pkg::pos_t                       set_out
);

    logic [wgm_pkg::POS_W-1:0] g_lvl [wgm_pkg::CLOSE_LEVELS+1];
    logic [wgm_pkg::POS_W-1:0] p_lvl [wgm_pkg::CLOSE_LEVELS+1];

    always_comb begin
        // Propagate into position k comes from a '*' at k-1
        g_lvl[0]    = set_in;
        p_lvl[0][0] = 1'b0;
        for (int k = 1; k < wgm_pkg::POS_W; k++) begin
            p_lvl[0][k] = run_mask[k-1];
        end
        // Double the span covered at each level
        for (int lvl = 0; lvl < wgm_pkg::CLOSE_LEVELS; lvl++) begin
            for (int k = 0; k < wgm_pkg::POS_W; k++) begin
                if (k >= (1 << lvl)) begin
                    g_lvl[lvl+1][k] = g_lvl[lvl][k]
                                    | (p_lvl[lvl][k] & g_lvl[lvl][k - (1 << lvl)]);
                    p_lvl[lvl+1][k] = p_lvl[lvl][k] & p_lvl[lvl][k - (1 << lvl)];
                end else begin
                    g_lvl[lvl+1][k] = g_lvl[lvl][k];
                    p_lvl[lvl+1][k] = p_lvl[lvl][k];
                end
            end
        end
        // Drop positions beyond the pattern length
        set_out = g_lvl[wgm_pkg::CLOSE_LEVELS] & keep_mask;
    end

endmodule

// ===== design/wgm_step.sv =====
`timescale 1ns / 1ps

// Advance the reachable position set by one text byte.
module wgm_step (
    input  wgm_pkg::item_t    item,
    input  wgm_pkg::pos_t     state,
    input  wgm_pkg::pattern_t pattern,
    input  wgm_pkg::len_t     used_len,
    output wgm_pkg::pos_t     next_set,
    output logic              is_match
);

    logic [wgm_pkg::PATTERN_MAX-1:0] run_mask;
    logic [wgm_pkg::PATTERN_MAX-1:0] one_mask;
    wgm_pkg::pos_t                   keep_mask;
    wgm_pkg::pos_t                   cur_set;
    wgm_pkg::pos_t                   cur_closed;
    wgm_pkg::pos_t                   moved_set;

    // Classify each pattern position against this byte
    always_comb begin
        for (int i = 0; i < wgm_pkg::PATTERN_MAX; i++) begin
            run_mask[i] = (pattern[i] == wgm_pkg::CH_ANY_RUN) && (i < int'(used_len));
            one_mask[i] = (pattern[i] != wgm_pkg::CH_ANY_RUN) && (i < int'(used_len))
                        && ((pattern[i] == wgm_pkg::CH_ANY_ONE)
                            || (pattern[i] == item.text_char));
        end
        for (int k = 0; k < wgm_pkg::POS_W; k++) begin
            keep_mask[k] = (k <= int'(used_len));
        end
    end

    // Restart from position zero on the first byte of a string
    assign cur_set = item.first_of_string ? wgm_pkg::POS_W'(1) : state;

    wgm_close u_close_cur (
        .set_in    (cur_set),
        .run_mask  (run_mask),
        .keep_mask (keep_mask),
        .set_out   (cur_closed)
    );

    // '*' holds its position, '?' or an equal byte moves one on
    always_comb begin
        moved_set = '0;
        for (int i = 0; i < wgm_pkg::PATTERN_MAX; i++) begin
            moved_set[i]   = moved_set[i] | (cur_closed[i] & run_mask[i]);
            moved_set[i+1] = cur_closed[i] & one_mask[i];
        end
    end

    wgm_close u_close_next (
        .set_in    (moved_set),
        .run_mask  (run_mask),
        .keep_mask (keep_mask),
        .set_out   (next_set)
    );

    assign is_match = next_set[used_len];

endmodule

// ===== design/wildcard_glob_matcher.sv =====
`timescale 1ns / 1ps

// Wildcard pattern matcher ('?' = any one byte, '*' = any run of bytes).
// Input channel s_*: one text byte per item with first/last-of-string
// flags. Result channel m_*: one is_match item per string, on its last
// byte; other bytes give no result.
// Configuration: cfg_wr_en/cfg_index/cfg_data write the pattern length
// (index 0) and the four 8-byte pattern words (indexes 1 to 4); other
// indexes are ignored. Write only while no string result is pending.
// Path: a last byte is taken into the input register, and its flag lands in
// the result register once that register is free (m_ready or empty).
// Throughput: one byte per cycle unless a last byte waits on m_ready, set by
// the combinational update of the reachable set (two closures, one shift step).
// Reset: the pattern is cleared, the set holds only position zero and
// both registers are empty.
// Stall: while a result waits on m_ready, middle bytes keep flowing at one
// per cycle; the next last byte is taken into the input register and holds
// s_ready low until the pending result is taken.
module wildcard_glob_matcher (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [wgm_pkg::CHAR_W-1:0]          s_text_char,
    input  logic                                s_first_of_string,
    input  logic                                s_last_of_string,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_is_match,
    input  logic                                cfg_wr_en,
    input  logic [wgm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wgm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    `include "assert_macros.svh"

    logic [wgm_pkg::PLEN_W-1:0]     pattern_length_reg;
    logic [wgm_pkg::PLEN_W-1:0]     pattern_length_next;
    logic [wgm_pkg::CFG_DATA_W-1:0] pattern_words_reg  [wgm_pkg::NUM_WORDS];
    logic [wgm_pkg::CFG_DATA_W-1:0] pattern_words_next [wgm_pkg::NUM_WORDS];

    logic           in_valid_reg;
    logic           in_valid_next;
    wgm_pkg::item_t in_item_reg;
    wgm_pkg::item_t in_item_next;
    wgm_pkg::pos_t  state_reg;
    wgm_pkg::pos_t  state_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           is_match_reg;
    logic           is_match_next;

    wgm_pkg::pattern_t pattern_chars;
    wgm_pkg::len_t     used_len;
    wgm_pkg::pos_t     step_set;
    logic              step_match;
    logic              out_free;
    logic              advance;
    logic              tail_advance;
    logic              mid_advance;

    // Decode configuration writes
    always_comb begin
        pattern_length_next = pattern_length_reg;
        pattern_words_next  = pattern_words_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                wgm_pkg::REG_PATTERN_LENGTH: begin
                    pattern_length_next = cfg_data[wgm_pkg::PLEN_W-1:0];
                end
                wgm_pkg::REG_CHARS_A: begin
                    pattern_words_next[0] = cfg_data;
                end
                wgm_pkg::REG_CHARS_B: begin
                    pattern_words_next[1] = cfg_data;
                end
                wgm_pkg::REG_CHARS_C: begin
                    pattern_words_next[2] = cfg_data;
                end
                wgm_pkg::REG_CHARS_D: begin
                    pattern_words_next[3] = cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Unpack pattern bytes, low byte first
    for (genvar gi = 0; gi < wgm_pkg::PATTERN_MAX; gi++) begin : g_chars
        assign pattern_chars[gi] = pattern_words_reg[gi / wgm_pkg::CHARS_PER_WORD]
            [(gi % wgm_pkg::CHARS_PER_WORD) * wgm_pkg::CHAR_W +: wgm_pkg::CHAR_W];
    end

    // Clamp the length to the pattern size
    assign used_len = (pattern_length_reg > wgm_pkg::PLEN_W'(wgm_pkg::PATTERN_MAX))
                    ? wgm_pkg::LEN_W'(wgm_pkg::PATTERN_MAX)
                    : wgm_pkg::LEN_W'(pattern_length_reg);

    wgm_step u_step (
        .item     (in_item_reg),
        .state    (state_reg),
        .pattern  (pattern_chars),
        .used_len (used_len),
        .next_set (step_set),
        .is_match (step_match)
    );

    // Handshake: a last byte waits for a free result register
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!in_item_reg.last_of_string || out_free);
    assign s_ready  = !in_valid_reg || advance;

    assign tail_advance = advance && in_item_reg.last_of_string;
    assign mid_advance  = advance && !in_item_reg.last_of_string;

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_item_next   = in_item_reg;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        is_match_next  = is_match_reg;

        // Hold or drain the result register
        if (m_ready) begin
            out_valid_next = 1'b0;
        end

        // Advance the item in the input register
        if (advance) begin
            in_valid_next = 1'b0;
            if (in_item_reg.last_of_string) begin
                state_next     = wgm_pkg::POS_W'(1);
                out_valid_next = 1'b1;
                is_match_next  = step_match;
            end else begin
                state_next = step_set;
            end
        end

        // Capture a new item
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_item_next  = '{text_char:       s_text_char,
                              first_of_string: s_first_of_string,
                              last_of_string:  s_last_of_string};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= '0;
            for (int w = 0; w < wgm_pkg::NUM_WORDS; w++) begin
                pattern_words_reg[w] <= '0;
            end
            in_valid_reg  <= 1'b0;
            state_reg     <= wgm_pkg::POS_W'(1);
            out_valid_reg <= 1'b0;
        end else begin
            pattern_length_reg <= pattern_length_next;
            pattern_words_reg  <= pattern_words_next;
            in_valid_reg       <= in_valid_next;
            state_reg          <= state_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        in_item_reg  <= in_item_next;
        is_match_reg <= is_match_next;
    end

    assign m_valid    = out_valid_reg;
    assign m_is_match = is_match_reg;

    // Checks
    `ASSERT_NEXT(a_restart_after_end, tail_advance, state_reg == wgm_pkg::POS_W'(1) && m_valid)
    `ASSERT_NEXT(a_no_result_mid_string, mid_advance && out_free, !m_valid)
    `ASSERT_NEXT(a_stage_holds, in_valid_reg && !advance, in_valid_reg && $stable(in_item_reg))

endmodule
